[hw/rtl/clps_pkg.sv]
// ----------------------------------------------------------------------------
// clps_pkg
// Shared constants and types of the cell load priority scorer.
// ----------------------------------------------------------------------------
package clps_pkg;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SIZE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOAD_RADIUS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNLOAD_RADIUS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_ENABLE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_WEIGHT    = 3'd4;

   localparam logic [30:0] RST_CELL_SIZE     = 31'd4194304;
   localparam logic [30:0] RST_LOAD_RADIUS   = 31'd16777216;
   localparam logic [30:0] RST_UNLOAD_RADIUS = 31'd20971520;
   localparam logic [14:0] RST_DIR_WEIGHT    = 15'd2048;

   // Square root pipeline: 64 bit radicand, one root bit per stage.
   localparam int SQ_IN_W   = 64;
   localparam int SQ_ROOT_W = 32;

   // Divider pipeline: 31 bit divisor.
   localparam int DIV_D_W = 31;
   localparam int DIV_Q_W = 17;
   localparam int DIV_N_W = DIV_D_W + DIV_Q_W;

   localparam logic [16:0] Q14_ONE     = 17'd16384;
   localparam logic [31:0] BONUS_ROUND = 32'd4096;

   // Geometry handed from the front end to the root and divide stages.
   typedef struct packed {
      logic [63:0] dist_sq;
      logic        sat;
      logic        nonzero;
      logic [61:0] len_sq;
      logic [46:0] dot_mag;
      logic        dot_neg;
   } clps_geom_type;

endpackage

[hw/rtl/cell_load_priority_scorer_top.sv]
// ----------------------------------------------------------------------------
// cell_load_priority_scorer_top
// Scores one grid cell per word for streaming priority from camera pose.
// ----------------------------------------------------------------------------
// The scorer takes one request word per clock while req_stall is low and
// returns one response word per request, in order, after six front end stages,
// a 32 stage square root (distance and direction length side by side), one
// setup stage, a 17 stage divider (distance score and cosine side by side),
// one bonus stage and the output register. A stalled response freezes the
// whole pipeline in place, so request stall follows response stall while a
// response is held. Configuration registers are written through the csr port,
// which is always ready; write them only while nothing is in flight.
module cell_load_priority_scorer_top
   import clps_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [15:0]   req_cell_x,
   input  logic signed [15:0]   req_cell_z,
   input  logic signed [31:0]   req_cam_x,
   input  logic signed [31:0]   req_cam_y,
   input  logic signed [31:0]   req_cam_z,
   input  logic signed [15:0]   req_view_x,
   input  logic signed [15:0]   req_view_y,
   input  logic signed [15:0]   req_view_z,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [17:0]          rsp_priority_res,
   output logic [31:0]          rsp_distance,
   output logic                 rsp_within_load,
   output logic                 rsp_beyond_unload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   // Configuration registers.
   logic [30:0] cell_size_ff, load_radius_ff, unload_radius_ff;
   logic        dir_enable_ff;
   logic [14:0] dir_weight_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff     <= RST_CELL_SIZE;
         load_radius_ff   <= RST_LOAD_RADIUS;
         unload_radius_ff <= RST_UNLOAD_RADIUS;
         dir_enable_ff    <= 1'b1;
         dir_weight_ff    <= RST_DIR_WEIGHT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CELL_SIZE:     cell_size_ff     <= csr_wdata[30:0];
            CSR_LOAD_RADIUS:   load_radius_ff   <= csr_wdata[30:0];
            CSR_UNLOAD_RADIUS: unload_radius_ff <= csr_wdata[30:0];
            CSR_DIR_ENABLE:    dir_enable_ff    <= csr_wdata[0];
            CSR_DIR_WEIGHT:    dir_weight_ff    <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // The whole pipeline advances unless a finished word is held at the output.
   logic rsp_valid_ff;
   logic en;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // Front end.
   logic          geom_valid;
   clps_geom_type geom;

   clps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .cell_x    (req_cell_x),
      .cell_z    (req_cell_z),
      .cam_x     (req_cam_x),
      .cam_y     (req_cam_y),
      .cam_z     (req_cam_z),
      .view_x    (req_view_x),
      .view_y    (req_view_y),
      .view_z    (req_view_z),
      .cell_size (cell_size_ff),
      .out_valid (geom_valid),
      .geom      (geom)
   );

   // Distance and direction length roots.
   logic                 dist_valid, len_valid;
   logic [SQ_ROOT_W-1:0] dist_root, len_root;
   logic [1:0]           dist_side;
   logic [47:0]          len_side;

   clps_sqrt #(.SIDE_W(2)) u_sqrt_dist (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (geom_valid),
      .radicand  (geom.dist_sq),
      .side_in   ({geom.sat, geom.nonzero}),
      .out_valid (dist_valid),
      .root      (dist_root),
      .side_out  (dist_side)
   );

   clps_sqrt #(.SIDE_W(48)) u_sqrt_len (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (geom_valid),
      .radicand  ({2'b00, geom.len_sq}),
      .side_in   ({geom.dot_neg, geom.dot_mag}),
      .out_valid (len_valid),
      .root      (len_root),
      .side_out  (len_side)
   );

   // Setup stage: saturated distance, radius compares, divider operands.
   logic [31:0]        dist_full;
   logic               lt_in;
   logic [30:0]        diff_in;
   logic               prep_valid_ff;
   logic [DIV_N_W-1:0] prep_num_s_ff, prep_num_c_ff;
   logic [DIV_D_W-1:0] prep_den_s_ff, prep_den_c_ff;
   logic [35:0]        prep_side_s_ff;
   logic               prep_neg_ff;

   always_comb begin
      dist_full = dist_side[1] ? 32'hFFFF_FFFF : dist_root;
      lt_in     = dist_full < {1'b0, load_radius_ff};
      diff_in   = lt_in ? 31'({1'b0, load_radius_ff} - dist_full) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (en) begin
         prep_valid_ff <= dist_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prep_num_s_ff  <= {3'b000, diff_in, 14'b0};
         prep_den_s_ff  <= load_radius_ff;
         prep_side_s_ff <= {dist_side[0], lt_in,
                            dist_full <= {1'b0, load_radius_ff},
                            dist_full > {1'b0, unload_radius_ff},
                            dist_full};
         prep_num_c_ff  <= {1'b0, len_side[46:0]};
         prep_den_c_ff  <= len_root[DIV_D_W-1:0];
         prep_neg_ff    <= len_side[47];
      end
   end

   // Distance score and cosine quotients.
   logic               score_valid, cos_valid;
   logic [DIV_Q_W-1:0] score_q, cos_q;
   logic [35:0]        score_side;
   logic               cos_neg;

   clps_div #(.SIDE_W(36)) u_div_score (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (prep_valid_ff),
      .dividend  (prep_num_s_ff),
      .divisor   (prep_den_s_ff),
      .side_in   (prep_side_s_ff),
      .out_valid (score_valid),
      .quotient  (score_q),
      .side_out  (score_side)
   );

   clps_div #(.SIDE_W(1)) u_div_cos (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (prep_valid_ff),
      .dividend  (prep_num_c_ff),
      .divisor   (prep_den_c_ff),
      .side_in   (prep_neg_ff),
      .out_valid (cos_valid),
      .quotient  (cos_q),
      .side_out  (cos_neg)
   );

   // Bonus stage: clamp the cosine, scale by the weight, round half up.
   logic [16:0] cos_clamp;
   logic [15:0] cos_shift;
   logic [30:0] bonus_prod;
   logic [31:0] bonus_sum;
   logic [17:0] bonus_in;
   logic        post_valid_ff;
   logic [14:0] post_score_ff;
   logic [17:0] post_bonus_ff;
   logic [31:0] post_dist_ff;
   logic        post_within_ff, post_beyond_ff;

   always_comb begin
      cos_clamp  = (cos_q > Q14_ONE) ? Q14_ONE : cos_q;
      cos_shift  = cos_neg ? 16'(Q14_ONE - cos_clamp) : 16'(Q14_ONE + cos_clamp);
      bonus_prod = cos_shift * dir_weight_ff;
      bonus_sum  = {1'b0, bonus_prod} + BONUS_ROUND;
      // No bonus with the feature off or with the camera on the cell centre.
      bonus_in   = (dir_enable_ff && score_side[35]) ? bonus_sum[30:13] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         post_valid_ff <= 1'b0;
      end else if (en) begin
         post_valid_ff <= score_valid;
      end
   end

   // The score reaches a full 1.0 (bit 14) with the camera on the cell centre.
   always_ff @(posedge clock) begin
      if (en) begin
         post_score_ff  <= score_side[34] ? score_q[14:0] : '0;
         post_bonus_ff  <= bonus_in;
         post_within_ff <= score_side[33];
         post_beyond_ff <= score_side[32];
         post_dist_ff   <= score_side[31:0];
      end
   end

   // Output register.
   logic [17:0] rsp_priority_ff;
   logic [31:0] rsp_distance_ff;
   logic        rsp_within_ff, rsp_beyond_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= post_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_priority_ff <= {3'b000, post_score_ff} + post_bonus_ff;
         rsp_distance_ff <= post_dist_ff;
         rsp_within_ff   <= post_within_ff;
         rsp_beyond_ff   <= post_beyond_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_priority_res  = rsp_priority_ff;
   assign rsp_distance      = rsp_distance_ff;
   assign rsp_within_load   = rsp_within_ff;
   assign rsp_beyond_unload = rsp_beyond_ff;

   // The two root pipelines and the two divider pipelines stay in lockstep.
   a_sqrt_lockstep: assert property (@(posedge clock) disable iff (reset)
      dist_valid == len_valid)
      else $error("distance and length root pipelines out of step");

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      score_valid == cos_valid)
      else $error("score and cosine divider pipelines out of step");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid after reset");

   // Radii are below 2^31, so a saturated distance is never within reach.
   a_saturated_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_distance_ff == 32'hFFFF_FFFF) |-> (!rsp_within_ff && rsp_beyond_ff))
      else $error("saturated distance with inconsistent radius flags");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_priority_ff)))
      else $error("held response word changed");

endmodule

[hw/rtl/clps_front.sv]
// ----------------------------------------------------------------------------
// clps_front
// Six stage front end: cell centre, deltas, squares, scaled direction
// vector, dot product and squared length.
// ----------------------------------------------------------------------------
module clps_front
   import clps_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic signed [15:0]  cell_x,
   input  logic signed [15:0]  cell_z,
   input  logic signed [31:0]  cam_x,
   input  logic signed [31:0]  cam_y,
   input  logic signed [31:0]  cam_z,
   input  logic signed [15:0]  view_x,
   input  logic signed [15:0]  view_y,
   input  logic signed [15:0]  view_z,
   input  logic [30:0]         cell_size,
   output logic                out_valid,
   output clps_geom_type       geom
);

   // Stage 1: cell index times cell size.
   logic               s1_valid_ff;
   logic signed [47:0] prod_x_in, prod_z_in;
   logic signed [47:0] s1_prod_x_ff, s1_prod_z_ff;
   logic [29:0]        s1_half_ff;
   logic signed [31:0] s1_cam_x_ff, s1_cam_y_ff, s1_cam_z_ff;
   logic signed [15:0] s1_vx_ff, s1_vy_ff, s1_vz_ff;

   assign prod_x_in = cell_x * $signed({1'b0, cell_size});
   assign prod_z_in = cell_z * $signed({1'b0, cell_size});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_prod_x_ff <= prod_x_in;
         s1_prod_z_ff <= prod_z_in;
         s1_half_ff   <= cell_size[30:1];
         s1_cam_x_ff  <= cam_x;
         s1_cam_y_ff  <= cam_y;
         s1_cam_z_ff  <= cam_z;
         s1_vx_ff     <= view_x;
         s1_vy_ff     <= view_y;
         s1_vz_ff     <= view_z;
      end
   end

   // Stage 2: deltas and their magnitudes.
   logic               s2_valid_ff;
   logic signed [49:0] dx_in, dz_in;
   logic signed [32:0] dy_in;
   logic [48:0]        ax_in, ay_in, az_in;
   logic [48:0]        s2_ax_ff, s2_ay_ff, s2_az_ff;
   logic               s2_nx_ff, s2_ny_ff, s2_nz_ff;
   logic signed [15:0] s2_vx_ff, s2_vy_ff, s2_vz_ff;

   always_comb begin
      dx_in = 50'(s1_prod_x_ff) + $signed({20'b0, s1_half_ff}) - 50'(s1_cam_x_ff);
      dz_in = 50'(s1_prod_z_ff) + $signed({20'b0, s1_half_ff}) - 50'(s1_cam_z_ff);
      dy_in = -33'(s1_cam_y_ff);
      ax_in = dx_in[49] ? 49'(-dx_in) : 49'(dx_in);
      az_in = dz_in[49] ? 49'(-dz_in) : 49'(dz_in);
      ay_in = dy_in[32] ? {16'b0, 33'(-dy_in)} : {16'b0, dy_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ax_ff <= ax_in;
         s2_ay_ff <= ay_in;
         s2_az_ff <= az_in;
         s2_nx_ff <= dx_in[49];
         s2_ny_ff <= dy_in[32];
         s2_nz_ff <= dz_in[49];
         s2_vx_ff <= s1_vx_ff;
         s2_vy_ff <= s1_vy_ff;
         s2_vz_ff <= s1_vz_ff;
      end
   end

   // Stage 3: squares, overflow flag and the shift that brings every
   // magnitude below 2^30. The OR of the magnitudes has the bit length of
   // their maximum.
   logic               s3_valid_ff;
   logic [48:0]        or_all;
   logic [4:0]         shift_in;
   logic               big_in;
   logic [63:0]        sq_x_in, sq_y_in, sq_z_in;
   logic [63:0]        s3_sq_x_ff, s3_sq_y_ff, s3_sq_z_ff;
   logic               s3_big_ff, s3_nonzero_ff;
   logic [4:0]         s3_shift_ff;
   logic [48:0]        s3_ax_ff, s3_ay_ff, s3_az_ff;
   logic               s3_nx_ff, s3_ny_ff, s3_nz_ff;
   logic signed [15:0] s3_vx_ff, s3_vy_ff, s3_vz_ff;

   assign or_all = s2_ax_ff | s2_ay_ff | s2_az_ff;

   always_comb begin
      shift_in = '0;
      for (int i = 30; i < 49; i++) begin
         if (or_all[i]) begin
            shift_in = 5'(i - 29);
         end
      end
   end

   assign big_in  = (|s2_ax_ff[48:32]) | (|s2_ay_ff[48:32]) | (|s2_az_ff[48:32]);
   assign sq_x_in = s2_ax_ff[31:0] * s2_ax_ff[31:0];
   assign sq_y_in = s2_ay_ff[31:0] * s2_ay_ff[31:0];
   assign sq_z_in = s2_az_ff[31:0] * s2_az_ff[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_sq_x_ff    <= sq_x_in;
         s3_sq_y_ff    <= sq_y_in;
         s3_sq_z_ff    <= sq_z_in;
         s3_big_ff     <= big_in;
         s3_nonzero_ff <= |or_all;
         s3_shift_ff   <= shift_in;
         s3_ax_ff      <= s2_ax_ff;
         s3_ay_ff      <= s2_ay_ff;
         s3_az_ff      <= s2_az_ff;
         s3_nx_ff      <= s2_nx_ff;
         s3_ny_ff      <= s2_ny_ff;
         s3_nz_ff      <= s2_nz_ff;
         s3_vx_ff      <= s2_vx_ff;
         s3_vy_ff      <= s2_vy_ff;
         s3_vz_ff      <= s2_vz_ff;
      end
   end

   // Stage 4: sum of squares and the scaled direction vector.
   logic               s4_valid_ff;
   logic [65:0]        sum_in;
   logic [29:0]        mag_x, mag_y, mag_z;
   logic signed [30:0] tx_in, ty_in, tz_in;
   logic [63:0]        s4_sum_ff;
   logic               s4_sat_ff, s4_nonzero_ff;
   logic signed [30:0] s4_tx_ff, s4_ty_ff, s4_tz_ff;
   logic signed [15:0] s4_vx_ff, s4_vy_ff, s4_vz_ff;

   always_comb begin
      sum_in = 66'(s3_sq_x_ff) + 66'(s3_sq_y_ff) + 66'(s3_sq_z_ff);
      mag_x  = 30'(s3_ax_ff >> s3_shift_ff);
      mag_y  = 30'(s3_ay_ff >> s3_shift_ff);
      mag_z  = 30'(s3_az_ff >> s3_shift_ff);
      tx_in  = s3_nx_ff ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
      ty_in  = s3_ny_ff ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
      tz_in  = s3_nz_ff ? -$signed({1'b0, mag_z}) : $signed({1'b0, mag_z});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_sum_ff     <= sum_in[63:0];
         s4_sat_ff     <= s3_big_ff | (|sum_in[65:64]);
         s4_nonzero_ff <= s3_nonzero_ff;
         s4_tx_ff      <= tx_in;
         s4_ty_ff      <= ty_in;
         s4_tz_ff      <= tz_in;
         s4_vx_ff      <= s3_vx_ff;
         s4_vy_ff      <= s3_vy_ff;
         s4_vz_ff      <= s3_vz_ff;
      end
   end

   // Stage 5: squares of the scaled vector and the dot product terms.
   logic               s5_valid_ff;
   logic signed [61:0] tsq_x_in, tsq_y_in, tsq_z_in;
   logic signed [46:0] dot_x_in, dot_y_in, dot_z_in;
   logic signed [61:0] s5_tsq_x_ff, s5_tsq_y_ff, s5_tsq_z_ff;
   logic signed [46:0] s5_dot_x_ff, s5_dot_y_ff, s5_dot_z_ff;
   logic [63:0]        s5_sum_ff;
   logic               s5_sat_ff, s5_nonzero_ff;

   assign tsq_x_in = s4_tx_ff * s4_tx_ff;
   assign tsq_y_in = s4_ty_ff * s4_ty_ff;
   assign tsq_z_in = s4_tz_ff * s4_tz_ff;
   assign dot_x_in = s4_tx_ff * s4_vx_ff;
   assign dot_y_in = s4_ty_ff * s4_vy_ff;
   assign dot_z_in = s4_tz_ff * s4_vz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_tsq_x_ff   <= tsq_x_in;
         s5_tsq_y_ff   <= tsq_y_in;
         s5_tsq_z_ff   <= tsq_z_in;
         s5_dot_x_ff   <= dot_x_in;
         s5_dot_y_ff   <= dot_y_in;
         s5_dot_z_ff   <= dot_z_in;
         s5_sum_ff     <= s4_sum_ff;
         s5_sat_ff     <= s4_sat_ff;
         s5_nonzero_ff <= s4_nonzero_ff;
      end
   end

   // Stage 6: squared length and dot product sums.
   logic               s6_valid_ff;
   logic signed [47:0] dot_in;
   clps_geom_type      geom_in, geom_ff;

   always_comb begin
      dot_in          = 48'(s5_dot_x_ff) + 48'(s5_dot_y_ff) + 48'(s5_dot_z_ff);
      geom_in.dist_sq = s5_sum_ff;
      geom_in.sat     = s5_sat_ff;
      geom_in.nonzero = s5_nonzero_ff;
      geom_in.len_sq  = $unsigned(s5_tsq_x_ff) + $unsigned(s5_tsq_y_ff)
                        + $unsigned(s5_tsq_z_ff);
      geom_in.dot_neg = dot_in[47];
      geom_in.dot_mag = dot_in[47] ? 47'(-dot_in) : 47'(dot_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (en) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         geom_ff <= geom_in;
      end
   end

   assign out_valid = s6_valid_ff;
   assign geom      = geom_ff;

endmodule

[hw/rtl/clps_sqrt.sv]
// ----------------------------------------------------------------------------
// clps_sqrt
// Pipelined integer square root, one root bit per stage, with a sideband
// that travels alongside the radicand.
// ----------------------------------------------------------------------------
module clps_sqrt
   import clps_pkg::*;
#(
   parameter int SIDE_W = 1
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [SQ_IN_W-1:0]   radicand,
   input  logic [SIDE_W-1:0]    side_in,
   output logic                 out_valid,
   output logic [SQ_ROOT_W-1:0] root,
   output logic [SIDE_W-1:0]    side_out
);

   // The remainder never exceeds twice the partial root.
   localparam int RW = SQ_ROOT_W + 3;

   logic [SQ_IN_W-1:0]   n_ff    [SQ_ROOT_W];
   logic [RW-1:0]        rem_ff  [SQ_ROOT_W];
   logic [SQ_ROOT_W-1:0] root_ff [SQ_ROOT_W];
   logic [SIDE_W-1:0]    side_ff [SQ_ROOT_W];
   logic                 valid_ff[SQ_ROOT_W];

   genvar k;
   for (k = 0; k < SQ_ROOT_W; k++) begin : g_stage
      logic [SQ_IN_W-1:0]   n_prev;
      logic [RW-1:0]        rem_prev;
      logic [SQ_ROOT_W-1:0] root_prev;
      logic [SIDE_W-1:0]    side_prev;
      logic                 valid_prev;
      logic [RW-1:0]        rem_sh, trial, rem_in;
      logic [SQ_ROOT_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign n_prev     = radicand;
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign side_prev  = side_in;
         assign valid_prev = in_valid;
      end else begin : g_rest
         assign n_prev     = n_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_prev[RW-3:0], n_prev[SQ_IN_W-1 -: 2]};
         trial  = RW'({root_prev, 2'b01});
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_prev[SQ_ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_prev[SQ_ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k]    <= n_prev << 2;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[SQ_ROOT_W-1];
   assign root      = root_ff[SQ_ROOT_W-1];
   assign side_out  = side_ff[SQ_ROOT_W-1];

endmodule

[hw/rtl/clps_div.sv]
// ----------------------------------------------------------------------------
// clps_div
// Pipelined restoring divider, one quotient bit per stage. The upper
// DIV_D_W bits of the dividend must be below the divisor.
// ----------------------------------------------------------------------------
module clps_div
   import clps_pkg::*;
#(
   parameter int SIDE_W = 1
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [DIV_N_W-1:0] dividend,
   input  logic [DIV_D_W-1:0] divisor,
   input  logic [SIDE_W-1:0]  side_in,
   output logic               out_valid,
   output logic [DIV_Q_W-1:0] quotient,
   output logic [SIDE_W-1:0]  side_out
);

   logic [DIV_D_W-1:0] r_ff    [DIV_Q_W];
   logic [DIV_Q_W-1:0] low_ff  [DIV_Q_W];
   logic [DIV_Q_W-1:0] q_ff    [DIV_Q_W];
   logic [DIV_D_W-1:0] den_ff  [DIV_Q_W];
   logic [SIDE_W-1:0]  side_ff [DIV_Q_W];
   logic               valid_ff[DIV_Q_W];

   genvar k;
   for (k = 0; k < DIV_Q_W; k++) begin : g_stage
      logic [DIV_D_W-1:0] r_prev, den_prev, r_in;
      logic [DIV_Q_W-1:0] low_prev, q_prev;
      logic [SIDE_W-1:0]  side_prev;
      logic               valid_prev;
      logic [DIV_D_W:0]   t, diff;
      logic               ge;

      if (k == 0) begin : g_first
         assign r_prev     = dividend[DIV_N_W-1:DIV_Q_W];
         assign low_prev   = dividend[DIV_Q_W-1:0];
         assign q_prev     = '0;
         assign den_prev   = divisor;
         assign side_prev  = side_in;
         assign valid_prev = in_valid;
      end else begin : g_rest
         assign r_prev     = r_ff[k-1];
         assign low_prev   = low_ff[k-1];
         assign q_prev     = q_ff[k-1];
         assign den_prev   = den_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      always_comb begin
         t    = {r_prev, low_prev[DIV_Q_W-1]};
         diff = t - {1'b0, den_prev};
         ge   = t >= {1'b0, den_prev};
         r_in = ge ? diff[DIV_D_W-1:0] : t[DIV_D_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k]    <= r_in;
            low_ff[k]  <= low_prev << 1;
            q_ff[k]    <= {q_prev[DIV_Q_W-2:0], ge};
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[DIV_Q_W-1];
   assign quotient  = q_ff[DIV_Q_W-1];
   assign side_out  = side_ff[DIV_Q_W-1];

endmodule
